// File: rtl/core/circular_log_record_manager_assert.svh
// Assertion macros for the circular log record manager.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef CIRCULAR_LOG_RECORD_MANAGER_ASSERT_SVH
`define CIRCULAR_LOG_RECORD_MANAGER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CLRM_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clrm check failed");
`define CLRM_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("clrm forbidden condition");
`else
`define CLRM_CHECK(name, prop)
`define CLRM_NEVER(name, cond)
`endif
`endif

// File: rtl/core/clrm_pkg.sv
// ---------------------------------------------------------------------------
// clrm_pkg
// Types, codes and defaults shared by the circular log record manager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package clrm_pkg;

  localparam int MAX_ROWS_DEF       = 64;
  localparam int AREA_ADDR_BITS_DEF = 20;

  localparam logic [20:0] AREA_BYTES_RST = 21'd1048576;
  localparam logic [6:0]  ROW_LIMIT_RST  = 7'd64;

  // configuration register indexes
  localparam logic REG_AREA_BYTES = 1'b0;
  localparam logic REG_ROW_LIMIT  = 1'b1;

  // command codes
  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_FIRST = 2'd1;
  localparam logic [1:0] OP_SIZE  = 2'd2;
  localparam logic [1:0] OP_INCR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_TOOLONG  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] store_len;
    logic [5:0]  key_row;
    logic [31:0] key_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  out_row;
    logic [31:0] out_id;
    logic [19:0] start_offset;
    logic [15:0] out_len;
    logic [6:0]  evicted;
  } out_t;

endpackage

// File: rtl/core/clrm_ram.sv
// ---------------------------------------------------------------------------
// clrm_ram
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/circular_log_record_manager.sv
// ---------------------------------------------------------------------------
// circular_log_record_manager
// Row table manager for a byte ring of variable-length log records.
// ---------------------------------------------------------------------------
// Usage: commands enter on in_valid/in_stall (in_data), one result item per
// command leaves on out_valid/out_stall (out_data). Configuration registers
// (area_bytes index 0, row_limit index 1) are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block
// is idle, and the block itself does not enforce this. One command is
// worked at a time; in_stall is high from acceptance until the result is
// loaded in the output register. A command first folds the oldest row
// index back under a lowered row limit, one step per fold. Lookups (get
// first, size, increment) then read the table; an oversized store is
// refused with a too-long status. A store evicts the oldest records one
// by one; unless the table is then empty, it reads the newest record and
// wraps its end offset into the area with a bit-serial remainder unit
// before it writes the new row. All table accesses share the single
// table RAM port.
// Reset (synchronous, rst_n low) erases every row through the valid flags
// at once; no clearing pass is needed. A stalled result holds in the output
// register; the next command is taken once the result has moved on there.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_log_record_manager_assert.svh"

module circular_log_record_manager
  import clrm_pkg::*;
#(
  parameter int MAX_ROWS       = MAX_ROWS_DEF,
  parameter int AREA_ADDR_BITS = AREA_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int LW  = (CW > 7) ? CW : 7;
  localparam int KW  = (CW > 6) ? CW : 6;
  localparam int AW  = AREA_ADDR_BITS;
  localparam int EW  = (AW + 1 > 21) ? AW + 1 : 21;
  localparam int SW  = ((AW + 1 > 16) ? AW + 1 : 16) + 1;
  localparam int XW  = ((AW > 16) ? AW : 16) + 1;
  localparam int XCW = $clog2(XW + 1);
  localparam int DW  = 32 + AW + 16;

  localparam logic [EW-1:0] AREA_TOP = EW'(1) << AW;
  localparam logic [LW-1:0] ROWS_TOP = LW'(MAX_ROWS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'h001,
    S_NORM  = 12'h002,
    S_DISP  = 12'h004,
    S_EVCHK = 12'h008,
    S_EVDO  = 12'h010,
    S_NEWRD = 12'h020,
    S_MOD   = 12'h040,
    S_PLACE = 12'h080,
    S_KLIVE = 12'h100,
    S_KNEXT = 12'h200,
    S_KRES  = 12'h400,
    S_OUT   = 12'h800
  } state_t;

  state_t             state_r, state_nxt;
  logic [20:0]        area_bytes_r;
  logic [6:0]         row_limit_r;
  logic [1:0]         op_r, op_nxt;
  logic [15:0]        slen_r, slen_nxt;
  logic [5:0]         krow_r, krow_nxt;
  logic [31:0]        kid_r, kid_nxt;
  logic [RW-1:0]      ox_r, ox_nxt;
  logic [RW-1:0]      oldest_index_r, oldest_index_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW:0]        filled_r, filled_nxt;
  logic [CW-1:0]      ev_r, ev_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [31:0]        id_r, id_nxt;
  logic [XW-1:0]      mx_r, mx_nxt;
  logic [AW:0]        mrem_r, mrem_nxt;
  logic [XCW-1:0]     mcnt_r, mcnt_nxt;
  logic [MAX_ROWS-1:0] valid_r, valid_nxt;
  out_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic [EW-1:0]  ab_ext, area_e;
  logic [AW:0]    area;
  logic [LW-1:0]  rl_ext, lim_e;
  logic [CW-1:0]  lim;
  logic [SW-1:0]  need;
  logic [CW:0]    nsum;
  logic [RW-1:0]  row_inc;
  logic [RW-1:0]  ox_inc;
  logic [AW+1:0]  mtrial;
  logic           ram_we;
  logic [RW-1:0]  ram_waddr, ram_raddr;
  logic [DW-1:0]  ram_wdata, ram_rdata;
  logic [31:0]    rd_id;
  logic [AW-1:0]  rd_start;
  logic [15:0]    rd_len;
  logic           accept;

  // effective register values
  assign ab_ext = EW'(area_bytes_r);
  assign area_e = (ab_ext == '0) ? EW'(1) : ((ab_ext > AREA_TOP) ? AREA_TOP : ab_ext);
  assign area   = area_e[AW:0];
  assign rl_ext = LW'(row_limit_r);
  assign lim_e  = (rl_ext == '0) ? LW'(1) : ((rl_ext > ROWS_TOP) ? ROWS_TOP : rl_ext);
  assign lim    = CW'(lim_e);

  // arithmetic terms used by the sequencer
  assign need    = SW'(slen_r) + SW'(filled_r);
  assign nsum    = (CW + 1)'(ox_r) + (CW + 1)'(count_r) - (CW + 1)'(1);
  assign row_inc = (CW'(row_r) + CW'(1) == lim) ? '0 : row_r + RW'(1);
  assign ox_inc  = (CW'(ox_r) + CW'(1) == lim) ? '0 : ox_r + RW'(1);
  assign mtrial  = {mrem_r, mx_r[XW-1]};

  assign rd_id    = ram_rdata[DW-1 -: 32];
  assign rd_start = ram_rdata[AW+15:16];
  assign rd_len   = ram_rdata[15:0];

  assign accept = in_valid && !in_stall;

  clrm_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ROWS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    slen_nxt         = slen_r;
    krow_nxt         = krow_r;
    kid_nxt          = kid_r;
    ox_nxt           = ox_r;
    oldest_index_nxt = oldest_index_r;
    count_nxt        = count_r;
    filled_nxt       = filled_r;
    ev_nxt           = ev_r;
    row_nxt          = row_r;
    id_nxt           = id_r;
    mx_nxt           = mx_r;
    mrem_nxt         = mrem_r;
    mcnt_nxt         = mcnt_r;
    valid_nxt        = valid_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    ram_we           = 1'b0;
    ram_waddr        = row_r;
    ram_wdata        = {id_r, mrem_r[AW-1:0], slen_r};
    ram_raddr        = ox_r;

    // drop the delivered result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_data.opcode;
          slen_nxt  = in_data.store_len;
          krow_nxt  = in_data.key_row;
          kid_nxt   = in_data.key_id;
          ox_nxt    = oldest_index_r;
          ev_nxt    = '0;
          res_nxt   = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // fold the oldest index under the row limit
        if (CW'(ox_r) >= lim) begin
          ox_nxt = RW'(CW'(ox_r) - lim);
        end else begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r)
          OP_STORE: begin
            if ((AW + 1)'(slen_r) > area || (SW'(slen_r) > SW'(area))) begin
              res_nxt.status = ST_TOOLONG;
              state_nxt      = S_OUT;
            end else begin
              state_nxt = S_EVCHK;
            end
          end
          OP_FIRST: begin
            if (count_r == '0) begin
              res_nxt.status = ST_NOTFOUND;
              state_nxt      = S_OUT;
            end else begin
              ram_raddr = ox_r;
              row_nxt   = ox_r;
              state_nxt = S_KRES;
            end
          end
          default: begin
            if (KW'(krow_r) < KW'(lim)) begin
              ram_raddr = RW'(krow_r);
              row_nxt   = RW'(krow_r);
              state_nxt = S_KLIVE;
            end else if (op_r == OP_SIZE || count_r == '0) begin
              res_nxt.status = ST_NOTFOUND;
              state_nxt      = S_OUT;
            end else begin
              ram_raddr = ox_r;
              row_nxt   = ox_r;
              state_nxt = S_KRES;
            end
          end
        endcase
      end
      S_EVCHK: begin
        // evict to make room, then to free a row
        if (SW'(area) < need) begin
          if (count_r == '0) begin
            filled_nxt = '0;
          end else begin
            ram_raddr = ox_r;
            state_nxt = S_EVDO;
          end
        end else if (count_r >= lim) begin
          ram_raddr = ox_r;
          state_nxt = S_EVDO;
        end else if (count_r != '0) begin
          if (nsum >= (CW + 1)'(lim)) begin
            row_nxt = RW'(nsum - (CW + 1)'(lim));
          end else begin
            row_nxt = RW'(nsum);
          end
          ram_raddr = (nsum >= (CW + 1)'(lim)) ? RW'(nsum - (CW + 1)'(lim)) : RW'(nsum);
          state_nxt = S_NEWRD;
        end else begin
          row_nxt   = '0;
          id_nxt    = '0;
          mrem_nxt  = '0;
          state_nxt = S_PLACE;
        end
      end
      S_EVDO: begin
        valid_nxt[ox_r]  = 1'b0;
        count_nxt        = count_r - CW'(1);
        filled_nxt       = (filled_r > (AW + 1)'(rd_len)) ? filled_r - (AW + 1)'(rd_len) : '0;
        ox_nxt           = ox_inc;
        oldest_index_nxt = ox_inc;
        ev_nxt           = ev_r + CW'(1);
        state_nxt        = S_EVCHK;
      end
      S_NEWRD: begin
        // newest record known: next id, next row, end offset to wrap
        id_nxt    = rd_id + 32'd1;
        row_nxt   = row_inc;
        mx_nxt    = XW'(rd_start) + XW'(rd_len);
        mrem_nxt  = '0;
        mcnt_nxt  = XCW'(XW);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // restoring remainder, one bit a cycle
        if (mcnt_r != '0) begin
          mrem_nxt = (mtrial >= (AW + 2)'(area)) ? (AW + 1)'(mtrial - (AW + 2)'(area))
                                                 : (AW + 1)'(mtrial);
          mx_nxt   = mx_r << 1;
          mcnt_nxt = mcnt_r - XCW'(1);
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        ram_we          = 1'b1;
        valid_nxt[row_r] = 1'b1;
        count_nxt       = count_r + CW'(1);
        if (count_r == '0) begin
          oldest_index_nxt = row_r;
        end
        filled_nxt           = filled_r + (AW + 1)'(slen_r);
        res_nxt.status       = ST_OK;
        res_nxt.out_row      = 6'(row_r);
        res_nxt.out_id       = id_r;
        res_nxt.start_offset = 20'(mrem_r);
        res_nxt.out_len      = slen_r;
        res_nxt.evicted      = 7'(ev_r);
        state_nxt            = S_OUT;
      end
      S_KLIVE: begin
        if (valid_r[row_r] && rd_id == kid_r) begin
          if (op_r == OP_SIZE) begin
            res_nxt.status  = ST_OK;
            res_nxt.out_row = 6'(row_r);
            res_nxt.out_id  = rd_id;
            res_nxt.out_len = rd_len;
            state_nxt       = S_OUT;
          end else begin
            id_nxt    = rd_id;
            ram_raddr = row_inc;
            row_nxt   = row_inc;
            state_nxt = S_KNEXT;
          end
        end else if (op_r == OP_SIZE || count_r == '0) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt      = S_OUT;
        end else begin
          ram_raddr = ox_r;
          row_nxt   = ox_r;
          state_nxt = S_KRES;
        end
      end
      S_KNEXT: begin
        if (valid_r[row_r] && rd_id >= id_r) begin
          res_nxt.status  = ST_OK;
          res_nxt.out_row = 6'(row_r);
          res_nxt.out_id  = rd_id;
          res_nxt.out_len = rd_len;
        end else begin
          res_nxt.status = ST_NOTFOUND;
        end
        state_nxt = S_OUT;
      end
      S_KRES: begin
        res_nxt.status  = ST_OK;
        res_nxt.out_row = 6'(row_r);
        res_nxt.out_id  = rd_id;
        res_nxt.out_len = rd_len;
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        // hand the item to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      area_bytes_r   <= AREA_BYTES_RST;
      row_limit_r    <= ROW_LIMIT_RST;
      oldest_index_r <= '0;
      count_r        <= '0;
      filled_r       <= '0;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      oldest_index_r <= oldest_index_nxt;
      count_r        <= count_nxt;
      filled_r       <= filled_nxt;
      valid_r        <= valid_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AREA_BYTES: area_bytes_r <= cfg_wdata;
          REG_ROW_LIMIT:  row_limit_r  <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    slen_r     <= slen_nxt;
    krow_r     <= krow_nxt;
    kid_r      <= kid_nxt;
    ox_r       <= ox_nxt;
    ev_r       <= ev_nxt;
    row_r      <= row_nxt;
    id_r       <= id_nxt;
    mx_r       <= mx_nxt;
    mrem_r     <= mrem_nxt;
    mcnt_r     <= mcnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CLRM_NEVER(a_count_bound, count_r > CW'(MAX_ROWS))
  `CLRM_CHECK(a_accept_busy, accept |=> state_r != S_IDLE)
  `CLRM_CHECK(a_out_from_seq, $rose(out_valid_r) |-> $past(state_r == S_OUT))
  `CLRM_CHECK(a_place_room, state_r == S_PLACE |-> count_r < lim)

endmodule
